@@ rtl/core/dmr_pkg.sv @@
`timescale 1ns / 1ps

package dmr_pkg;

  // Ring geometry.
  localparam int HISTORY_DEPTH = 16;
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W = 6;

  // Command codes.
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_DUP = 3'd1;
  localparam logic [2:0] ST_ZERO = 3'd2;
  localparam logic [2:0] ST_MATCH = 3'd3;
  localparam logic [2:0] ST_NONE = 3'd4;

  typedef struct packed {
    logic        command;
    logic [31:0] msg_id;
    logic [31:0] sender;
    logic [31:0] dest;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [31:0]       found_id;
    logic [31:0]       found_sender;
    logic [31:0]       found_dest;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } out_item_t;

  // One ring entry.
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] sender;
    logic [31:0] dest;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic rd;
    logic take;
    logic emit_mid;
    logic adv;
    logic finish;
  } dmr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_skip;
    logic hit;
    logic is_query;
    logic pend_valid;
    logic scan_last;
    logic out_free;
  } dmr_stat_t;

endpackage

@@ rtl/core/dmr_ctrl.sv @@
`timescale 1ns / 1ps

module dmr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  dmr_pkg::dmr_stat_t st,
  output dmr_pkg::dmr_cmd_t  cmd,
  output logic              ready
);
  import dmr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // Sequencing of one transaction through the ring scan.
  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = st.in_skip ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (st.hit && !st.is_query) begin
          // Duplicate id: keep the entry and report it.
          cmd.take = 1'b1;
          state_next = S_DONE;
        end else if (st.hit && st.pend_valid && !st.out_free) begin
          // An earlier match is still waiting for the output register.
          state_next = S_CMP;
        end else begin
          if (st.hit) begin
            cmd.take = 1'b1;
            cmd.emit_mid = st.pend_valid;
          end
          cmd.adv = 1'b1;
          state_next = st.scan_last ? S_DONE : S_RD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ready = (state == S_IDLE);

endmodule

@@ rtl/core/dmr_dpath.sv @@
`timescale 1ns / 1ps

module dmr_dpath (
  input  logic               clk,
  input  logic               rst,
  input  dmr_pkg::in_item_t  in_data,
  input  dmr_pkg::dmr_cmd_t  cmd,
  output dmr_pkg::dmr_stat_t st,
  output logic               out_valid,
  input  logic               out_stall,
  output dmr_pkg::out_item_t out_data
);
  import dmr_pkg::*;

  entry_t mem [HISTORY_DEPTH];
  entry_t rd_data;

  in_item_t item;
  logic item_zero;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] wp;
  logic [CNT_W-1:0] fill_count;

  logic pend_valid;
  entry_t pend_entry;
  logic [IDX_W-1:0] pend_slot;

  logic store_new;
  out_item_t final_res;
  out_item_t mid_res;

  // Status toward the controller.
  always_comb begin
    st.in_skip = ((in_data.command == CMD_STORE) && (in_data.msg_id == '0)) ||
                 (fill_count == '0);
    st.is_query = (item.command == CMD_QUERY);
    st.hit = (item.command == CMD_QUERY) ? (rd_data.dest == item.dest) :
                                           (rd_data.id == item.msg_id);
    st.pend_valid = pend_valid;
    st.scan_last = ((CNT_W'(idx) + CNT_W'(1)) == fill_count);
    st.out_free = !out_valid || !out_stall;
  end

  // Latched transaction and scan index.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
      item_zero <= (in_data.command == CMD_STORE) && (in_data.msg_id == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= '0;
    end else if (cmd.adv) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Ring memory with registered read port.
  assign store_new = cmd.finish && (item.command == CMD_STORE) && !item_zero && !pend_valid;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[idx];
    end
    if (store_new) begin
      mem[wp] <= '{id: item.msg_id, sender: item.sender, dest: item.dest};
    end
  end

  // Write pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      fill_count <= '0;
    end else if (store_new) begin
      wp <= (wp == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wp + IDX_W'(1);
      if (fill_count != CNT_W'(HISTORY_DEPTH)) begin
        fill_count <= fill_count + CNT_W'(1);
      end
    end
  end

  // Held match: a query match waits here until the next match or the scan end
  // tells whether it is the final one. A duplicate store's hit is also held here.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.load) begin
      pend_valid <= 1'b0;
    end else if (cmd.take) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_entry <= rd_data;
      pend_slot <= idx;
    end
  end

  // Result selection.
  always_comb begin
    mid_res = '{status: ST_MATCH, found_id: pend_entry.id, found_sender: pend_entry.sender,
                found_dest: pend_entry.dest, slot: SLOT_W'(pend_slot), last: 1'b0};
    final_res = '{status: ST_NONE, found_id: '0, found_sender: '0, found_dest: '0,
                  slot: '0, last: 1'b1};
    if (item.command == CMD_QUERY) begin
      if (pend_valid) begin
        final_res = mid_res;
        final_res.last = 1'b1;
      end
    end else if (item_zero) begin
      final_res.status = ST_ZERO;
    end else if (pend_valid) begin
      final_res = mid_res;
      final_res.status = ST_DUP;
      final_res.last = 1'b1;
    end else begin
      final_res = '{status: ST_STORED, found_id: item.msg_id, found_sender: item.sender,
                    found_dest: item.dest, slot: SLOT_W'(wp), last: 1'b1};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_mid || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_mid) begin
      out_data <= mid_res;
    end else if (cmd.finish) begin
      out_data <= final_res;
    end
  end

  // A result is only loaded when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_mid || cmd.finish) |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting result");

  // An intermediate result always releases a held query match.
  a_mid_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_mid |-> (pend_valid && (item.command == CMD_QUERY)))
    else $error("intermediate result without a held query match");

  // A new store always leaves the ring non-empty.
  a_store_fill: assert property (@(posedge clk) disable iff (rst)
    store_new |=> (fill_count != '0))
    else $error("fill count empty after a store");

  // The fill count never passes the ring depth.
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(HISTORY_DEPTH))
    else $error("fill count beyond ring depth");

endmodule

@@ rtl/core/dedup_message_ring.sv @@
`timescale 1ns / 1ps

// Duplicate-suppressing ring of message headers.
// Input channel (in_valid, in_stall, in_data): one transaction is a store
// or a query command. A store with a zero id returns a single ignore result;
// a store whose id is already held returns the held entry as a duplicate;
// any other store is written at the write pointer and returns the slot used.
// A query returns every held entry whose destination matches, in slot order,
// with last set on the final one, or a single no-match result.
// Output channel (out_valid, out_stall, out_data) is fed from an output
// register, so a finished result may wait while the ring moves on.
// Timing: one transaction at a time. The scan reads the ring entries in turn
// through the memory's registered read port (state S_RD, then S_CMP for each),
// the scan is skipped when the ring is empty or the id is zero, and a
// duplicate ends its scan at the first hit.
// Reset clears the write pointer, fill count, controller and output valid;
// the ring contents need no clearing since only filled slots are searched.
// A stalled receiver holds the output; the scan pauses on the next result.
module dedup_message_ring (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dmr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dmr_pkg::out_item_t out_data
);
  import dmr_pkg::*;

  dmr_cmd_t cmd;
  dmr_stat_t st;
  logic ready;

  dmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .ready    (ready)
  );

  dmr_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = !ready;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import dmr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // When set, neither side inserts idle or stall cycles.
  bit quiet = 1'b0;

  int fail_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int matches_seen = 0;
  int dups_seen = 0;

  // Shadow copy of the header ring.
  logic [31:0]      ring_id [HISTORY_DEPTH];
  logic [31:0]      ring_sender [HISTORY_DEPTH];
  logic [31:0]      ring_dest [HISTORY_DEPTH];
  int               next_slot = 0;
  int               held_count = 0;
  out_item_t        ring_responses_due[$];

  // Node numbers that queries and stores mostly use, so matches are common.
  logic [31:0] node_pool [4] = '{32'h0, 32'h1, 32'h2, 32'hFFFF_FFFF};

  dedup_message_ring dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic out_item_t make_result(logic [2:0] status, logic [31:0] id,
                                            logic [31:0] snd, logic [31:0] dst,
                                            int slot, logic last);
    out_item_t r;
    r.status = status;
    r.found_id = id;
    r.found_sender = snd;
    r.found_dest = dst;
    r.slot = SLOT_W'(slot);
    r.last = last;
    return r;
  endfunction

  // Work out the results of one accepted transaction and update the shadow ring.
  function automatic void model_ring_command(in_item_t it);
    out_item_t prev;
    bit        have_prev;
    have_prev = 1'b0;
    if (it.command == CMD_STORE) begin
      if (it.msg_id == 32'h0) begin
        ring_responses_due.push_back(make_result(ST_ZERO, '0, '0, '0, 0, 1'b1));
        return;
      end
      for (int i = 0; i < held_count; i++) begin
        if (ring_id[i] == it.msg_id) begin
          ring_responses_due.push_back(make_result(ST_DUP, ring_id[i], ring_sender[i],
                                                   ring_dest[i], i, 1'b1));
          return;
        end
      end
      ring_id[next_slot] = it.msg_id;
      ring_sender[next_slot] = it.sender;
      ring_dest[next_slot] = it.dest;
      ring_responses_due.push_back(make_result(ST_STORED, it.msg_id, it.sender, it.dest,
                                               next_slot, 1'b1));
      next_slot = (next_slot + 1 >= HISTORY_DEPTH) ? 0 : next_slot + 1;
      if (held_count < HISTORY_DEPTH) held_count++;
    end else begin
      // A match is queued only once the next one is known, so the final
      // one can carry the last mark.
      for (int i = 0; i < held_count; i++) begin
        if (ring_dest[i] == it.dest) begin
          if (have_prev) ring_responses_due.push_back(prev);
          prev = make_result(ST_MATCH, ring_id[i], ring_sender[i], ring_dest[i], i, 1'b0);
          have_prev = 1'b1;
        end
      end
      if (have_prev) begin
        prev.last = 1'b1;
        ring_responses_due.push_back(prev);
      end else begin
        ring_responses_due.push_back(make_result(ST_NONE, '0, '0, '0, 0, 1'b1));
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Predict on each accepted command and check each accepted result.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall) model_ring_command(in_data);
      if (out_valid && !out_stall) begin
        if (ring_responses_due.size() == 0) begin
          $error("unexpected result: status %0d id %0h", out_data.status, out_data.found_id);
          fail_count++;
        end else begin
          want = ring_responses_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("found_id", want.found_id, out_data.found_id);
          check_field("found_sender", want.found_sender, out_data.found_sender);
          check_field("found_dest", want.found_dest, out_data.found_dest);
          check_field("slot", 32'(want.slot), 32'(out_data.slot));
          check_field("last", 32'(want.last), 32'(out_data.last));
          results_checked++;
          if (want.status == ST_MATCH) matches_seen++;
          if (want.status == ST_DUP) dups_seen++;
        end
      end
    end
  end

  // Receiver: stall a random number of cycles, then take one result.
  always begin
    int hold;
    @(negedge clk);
    hold = quiet ? 0 : $urandom_range(0, 3);
    if (hold > 0) begin
      out_stall = 1'b1;
      repeat (hold) @(negedge clk);
    end
    out_stall = 1'b0;
    @(posedge clk);
    while (!out_valid) @(posedge clk);
  end

  // Send one transaction; called and returns at a falling edge.
  task automatic send_command(input in_item_t item);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = item;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic cmd, logic [31:0] id, logic [31:0] snd,
                                         logic [31:0] dst);
    in_item_t it;
    it.command = cmd;
    it.msg_id = id;
    it.sender = snd;
    it.dest = dst;
    return it;
  endfunction

  // Queries and stores on a ring that holds nothing yet.
  task automatic test_empty_ring();
    send_command(make_item(CMD_QUERY, 32'h0, 32'h0, 32'h0));
    send_command(make_item(CMD_STORE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_command(make_item(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // Field extremes, duplicates, zero ids and wrap of the write pointer.
  task automatic test_directed_headers();
    send_command(make_item(CMD_STORE, 32'h1, 32'h0, 32'h0));
    send_command(make_item(CMD_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_command(make_item(CMD_STORE, 32'h1, 32'h1234_5678, 32'h5));
    send_command(make_item(CMD_STORE, 32'h0, 32'h1234_5678, 32'h5));
    send_command(make_item(CMD_QUERY, 32'h0, 32'h0, 32'h0));
    send_command(make_item(CMD_QUERY, 32'h0, 32'h0, 32'h7));
    // Fill the ring with headers for one node.
    for (int i = 0; i < HISTORY_DEPTH - 2; i++)
      send_command(make_item(CMD_STORE, 32'd100 + i, 32'hA000 + i, 32'h5));
    send_command(make_item(CMD_QUERY, 32'h0, 32'h0, 32'h5));
    // These overwrite the two oldest slots, so id 1 is new again.
    send_command(make_item(CMD_STORE, 32'd200, 32'hBEEF, 32'h5));
    send_command(make_item(CMD_STORE, 32'h1, 32'hCAFE, 32'h0));
    send_command(make_item(CMD_STORE, 32'd200, 32'h0, 32'h0));
    send_command(make_item(CMD_QUERY, 32'h0, 32'h0, 32'h5));
  endtask

  // Every slot matches one query, back to back with no idling.
  task automatic test_full_match();
    quiet = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++)
      send_command(make_item(CMD_STORE, 32'h5A00_0000 + i, $urandom, 32'h77));
    send_command(make_item(CMD_QUERY, 32'h0, 32'h0, 32'h77));
    send_command(make_item(CMD_STORE, 32'h5A00_0003, 32'h0, 32'h0));
    send_command(make_item(CMD_QUERY, 32'h0, 32'h0, 32'h78));
    quiet = 1'b0;
  endtask

  // Mostly small id and node pools so duplicates and matches are frequent.
  function automatic in_item_t make_random_item();
    in_item_t it;
    int       pick;
    it.command = ($urandom_range(0, 9) < 3) ? CMD_QUERY : CMD_STORE;
    pick = $urandom_range(0, 9);
    if (pick == 0) it.msg_id = 32'h0;
    else if (pick <= 6) it.msg_id = $urandom_range(1, 24);
    else it.msg_id = $urandom;
    it.sender = $urandom;
    it.dest = ($urandom_range(0, 9) < 8) ? node_pool[$urandom_range(0, 3)] : $urandom;
    return it;
  endfunction

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      quiet = ((n % 60) >= 45);
      send_command(make_random_item());
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_ring();
    test_directed_headers();
    test_full_match();
    test_random_traffic(163);
    in_valid = 1'b0;

    while (ring_responses_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d store and query transactions; checked %0d results.",
             items_sent, results_checked);
    $display("Results included %0d query matches and %0d duplicates.",
             matches_seen, dups_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ dedup_message_ring.f @@
rtl/core/dmr_pkg.sv
rtl/core/dmr_ctrl.sv
rtl/core/dmr_dpath.sv
rtl/core/dedup_message_ring.sv
tb/testbench.sv
